// ----- design/wmef_pkg.sv -----
// Shared types, constants and helpers of the window minimum (erosion) filter.
// No dependencies; every other file of the block imports this package.
package wmef_pkg;

	localparam int WINDOW     = 15;
	localparam int HALF       = WINDOW / 2;
	localparam int SPAN       = 2 * HALF + 1;
	localparam int RING_ROWS  = 2 * HALF + 2;
	localparam int MAX_WIDTH  = 2048;

	localparam int CFG_W_W    = 12;
	localparam int CFG_H_W    = 13;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WEFF_W     = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W      = CFG_H_W;
	localparam int BANK_W     = $clog2(RING_ROWS);
	localparam int CNT_W      = $clog2(MAX_WIDTH * (2 ** CFG_H_W - 1) + SPAN + 1);

	// min tree is sized for the largest window and ring
	localparam int TREE_N     = 32;
	localparam int TREE_LVL   = 5;

	localparam int WIDTH_RESET_I  = 640;
	localparam int HEIGHT_RESET_I = 480;
	localparam logic [CFG_W_W-1:0] WIDTH_RESET  = CFG_W_W'(WIDTH_RESET_I);
	localparam logic [CFG_H_W-1:0] HEIGHT_RESET = CFG_H_W'(HEIGHT_RESET_I);
	localparam logic [CNT_W-1:0]   AREA_RESET   = CNT_W'(WIDTH_RESET_I * HEIGHT_RESET_I);

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic [7:0] pix_t;

	// one column minimum travelling down the cell row
	typedef struct packed {
		logic              vld;
		logic [BANK_W-1:0] tag;
		pix_t              val;
	} col_t;

	// column read issued by the control unit
	typedef struct packed {
		logic                 go;
		logic                 vld;
		logic                 emit;
		logic                 last;
		logic [BANK_W-1:0]    tag;
		logic [RING_ROWS-1:0] mask;
		logic [COL_W-1:0]     col;
	} rd_t;

	// line store write
	typedef struct packed {
		logic              en;
		logic [BANK_W-1:0] bank;
		logic [COL_W-1:0]  col;
	} wr_t;

	function automatic pix_t min_tree(input logic [TREE_N-1:0][7:0] v);
		logic [TREE_N-1:0][7:0] a;
		a = v;
		for (int lvl = 0; lvl < TREE_LVL; lvl++) begin
			for (int i = 0; i < TREE_N / 2; i++) begin
				a[i] = (a[2*i] < a[2*i+1]) ? a[2*i] : a[2*i+1];
			end
		end
		return a[0];
	endfunction

endpackage

// ----- design/wmef_line_bank.sv -----
// One row bank of the line store: one write port, one registered read port.
// Depends on wmef_pkg.
module wmef_line_bank import wmef_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [COL_W-1:0] waddr,
	input  pix_t             wdata,
	input  logic             re,
	input  logic [COL_W-1:0] raddr,
	output pix_t             rdata
);

	pix_t mem [MAX_WIDTH];
	pix_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/wmef_cell.sv -----
// One cell of the column-minimum row: holds one column minimum, passes it on.
// Depends on wmef_pkg.
module wmef_cell import wmef_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic              shift,
	input  col_t              din,
	input  logic [BANK_W-1:0] ctag,
	output col_t              dout,
	output pix_t              masked
);

	col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q.vld <= 1'b0;
		end else if (clr) begin
			col_q.vld <= 1'b0;
		end else if (shift) begin
			col_q <= din;
		end
	end

	assign dout = col_q;
	// columns of another row or past the frame end count as 255
	assign masked = (col_q.vld && col_q.tag == ctag) ? col_q.val : 8'hFF;

endmodule

// ----- design/wmef_ctrl.sv -----
// Position tracking: input and result counters of the frame, and the column
// read cursor feeding the line store. Depends on wmef_pkg.
module wmef_ctrl import wmef_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              restart,
	input  logic [WEFF_W-1:0] w_eff,
	input  logic [ROW_W-1:0]  h_eff,
	input  logic              en,
	input  logic              s_valid,
	input  logic              s_action,
	output logic              s_ready,
	output wr_t               wr,
	output rd_t               rd
);

	logic [COL_W-1:0]  w_m1;
	logic [ROW_W-1:0]  h_m1;
	logic [CNT_W-1:0]  area_q;

	// frame as the result order sees it
	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [BANK_W-1:0] in_bank_q;
	logic              in_done_q;
	logic [CNT_W-1:0]  emit_cnt_q;
	logic              mfrm_q;

	// read cursor
	logic [ROW_W-1:0]  rr_q;
	logic [COL_W-1:0]  rc_q;
	logic [BANK_W-1:0] rbank_q;
	logic [CNT_W-1:0]  rcnt_q;
	logic              efrm_q;

	logic              acc, wr_pix, wlast_col, fdiff;
	logic [ROW_W-1:0]  ir1;
	logic [COL_W-1:0]  ic1;
	logic              done1, rdy_o, olast;
	logic [ROW_W:0]    nr_o, nr_e;
	logic [COL_W:0]    nc_o;
	logic              dummy, dready, allow, go, last_read;
	logic [BANK_W-1:0] up, b0;
	logic [BANK_W:0]   nrows;
	logic [RING_ROWS-1:0] mask;

	assign w_m1 = COL_W'(w_eff - WEFF_W'(1));
	assign h_m1 = h_eff - ROW_W'(1);
	assign fdiff = mfrm_q != efrm_q;

	assign s_ready   = en && !fdiff;
	assign acc       = s_valid && s_ready;
	assign wr_pix    = acc && !s_action && !in_done_q;
	assign wlast_col = in_col_q == w_m1;

	always_comb begin
		ic1   = in_col_q;
		ir1   = in_row_q;
		done1 = in_done_q;
		if (wr_pix) begin
			if (wlast_col) begin
				ic1 = '0;
				ir1 = in_row_q + ROW_W'(1);
				if (in_row_q == h_m1) begin
					done1 = 1'b1;
				end
			end else begin
				ic1 = in_col_q + COL_W'(1);
			end
		end
	end

	always_comb begin
		nr_o = {1'b0, out_row_q} + (ROW_W+1)'(HALF);
		if (nr_o > {1'b0, h_m1}) begin
			nr_o = {1'b0, h_m1};
		end
		nc_o = {1'b0, out_col_q} + (COL_W+1)'(HALF);
		if (nc_o > {1'b0, w_m1}) begin
			nc_o = {1'b0, w_m1};
		end
	end

	assign rdy_o = acc && (done1 || {1'b0, ir1} > nr_o ||
		({1'b0, ir1} == nr_o && {1'b0, ic1} > nc_o));
	assign olast = out_row_q == h_m1 && out_col_q == w_m1;

	assign wr.en   = wr_pix;
	assign wr.bank = in_bank_q;
	assign wr.col  = in_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= AREA_RESET;
		end else begin
			area_q <= CNT_W'(w_eff * h_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_bank_q  <= '0;
			in_done_q  <= 1'b0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			emit_cnt_q <= '0;
			mfrm_q     <= 1'b0;
		end else if (restart) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_bank_q  <= '0;
			in_done_q  <= 1'b0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			emit_cnt_q <= '0;
			mfrm_q     <= 1'b0;
		end else if (rdy_o && olast) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_bank_q  <= '0;
			in_done_q  <= 1'b0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			emit_cnt_q <= '0;
			mfrm_q     <= !mfrm_q;
		end else begin
			in_row_q  <= ir1;
			in_col_q  <= ic1;
			in_done_q <= done1;
			if (wr_pix && wlast_col) begin
				in_bank_q <= (in_bank_q == BANK_W'(RING_ROWS - 1)) ? '0 :
					in_bank_q + BANK_W'(1);
			end
			if (rdy_o) begin
				emit_cnt_q <= emit_cnt_q + CNT_W'(1);
				if (out_col_q == w_m1) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

	// read cursor: one column minimum per cycle unless held, at most HALF columns ahead of results
	always_comb begin
		nr_e = {1'b0, rr_q} + (ROW_W+1)'(HALF);
		if (nr_e > {1'b0, h_m1}) begin
			nr_e = {1'b0, h_m1};
		end
	end

	assign dummy     = rcnt_q >= area_q;
	assign dready    = dummy || fdiff || in_done_q || {1'b0, in_row_q} > nr_e ||
		({1'b0, in_row_q} == nr_e && in_col_q > rc_q);
	assign allow     = fdiff || rcnt_q < emit_cnt_q + CNT_W'(HALF);
	assign go        = en && allow && dready;
	assign last_read = rcnt_q == area_q + CNT_W'(HALF - 1);

	// rows of the window that live in each bank
	always_comb begin
		up = (rr_q < ROW_W'(HALF)) ? BANK_W'(rr_q) : BANK_W'(HALF);
		b0 = (rbank_q >= up) ? rbank_q - up : BANK_W'((BANK_W+1)'(rbank_q) +
			(BANK_W+1)'(RING_ROWS) - (BANK_W+1)'(up));
		nrows = BANK_W'(nr_e - {1'b0, rr_q}) + (BANK_W+1)'(up) + (BANK_W+1)'(1);
	end

	always_comb begin : mask_gen
		logic [BANK_W:0] bb, dd;
		for (int b = 0; b < RING_ROWS; b++) begin
			bb = (BANK_W+1)'(b);
			dd = (bb >= {1'b0, b0}) ? bb - {1'b0, b0} :
				bb + (BANK_W+1)'(RING_ROWS) - {1'b0, b0};
			mask[b] = !dummy && dd < nrows;
		end
	end

	assign rd.go   = go;
	assign rd.vld  = !dummy;
	assign rd.emit = rcnt_q >= CNT_W'(HALF);
	assign rd.last = last_read;
	assign rd.tag  = rbank_q;
	assign rd.mask = mask;
	assign rd.col  = rc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rr_q    <= '0;
			rc_q    <= '0;
			rbank_q <= '0;
			rcnt_q  <= '0;
			efrm_q  <= 1'b0;
		end else if (restart) begin
			rr_q    <= '0;
			rc_q    <= '0;
			rbank_q <= '0;
			rcnt_q  <= '0;
			efrm_q  <= 1'b0;
		end else if (go) begin
			if (last_read) begin
				rr_q    <= '0;
				rc_q    <= '0;
				rbank_q <= '0;
				rcnt_q  <= '0;
				efrm_q  <= !efrm_q;
			end else begin
				rcnt_q <= rcnt_q + CNT_W'(1);
				if (!dummy) begin
					if (rc_q == w_m1) begin
						rc_q    <= '0;
						rr_q    <= rr_q + ROW_W'(1);
						rbank_q <= (rbank_q == BANK_W'(RING_ROWS - 1)) ? '0 :
							rbank_q + BANK_W'(1);
					end else begin
						rc_q <= rc_q + COL_W'(1);
					end
				end
			end
		end
	end

`ifndef SYNTHESIS
	// a new frame does not start writing while the cursor still reads the old one
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_pix |-> !fdiff)
		else $error("line store written while previous frame still read");

	// the cursor never runs more than H columns past the emitted results
	assert property (@(posedge clk) disable iff (!arst_n)
		!fdiff |-> rcnt_q <= emit_cnt_q + CNT_W'(HALF))
		else $error("read cursor ahead of result order");

	// a read of real pixels always covers at least one row bank
	assert property (@(posedge clk) disable iff (!arst_n)
		(go && !dummy) |-> mask != '0)
		else $error("column read with empty bank mask");
`endif

endmodule

// ----- design/window_min_erosion_filter.sv -----
// Square-window grayscale erosion (minimum filter) over an 8-bit image stream.
// Input channel s_axis: one item per clock when not held off; tuser = 0 carries
// a pixel in raster order, tuser = 1 is a flush tick. Output channel m_axis: one
// result per image pixel, in raster order, tlast on the final pixel of the frame.
// APB registers: 0x0 frame width, 0x4 frame height; a write restarts the frame.
// Throughput: one item per clock when not held off. A result passes the line
// store read, the cell row and the output register after the input that
// completes its window plus up to HALF further pixels where its window ends in
// the row's last columns: the column read cursor runs up to HALF columns ahead
// of the result, one line store read (all row banks at once) per cycle unless
// stalled. After the frame's last pixel, flush ticks release the pending
// results; the next frame's pixels are held off until the cursor has finished the old one.
// Reset: registers 640 x 480, all positions zero, no results pending. The line
// store needs no clearing; only pixels of the current frame are read.
// When the receiver stalls, the whole pipeline and s_axis_tready hold.
// Depends on wmef_pkg, wmef_ctrl, wmef_line_bank, wmef_cell.
module window_min_erosion_filter import wmef_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
	input  logic        s_axis_tuser,   // [0] action (1 = flush)
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] min_value
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [CFG_W_W-1:0] fw_q;
	logic [CFG_H_W-1:0] fh_q;
	logic [WEFF_W-1:0]  w_eff;
	logic [ROW_W-1:0]   h_eff;
	logic               restart, en;
	reg_idx_t           ridx;

	wr_t  wr;
	rd_t  rd, rd_s1;
	logic go_s1, emit_s2, last_s2;
	logic out_vld_q, out_last_q;
	pix_t out_min_q;

	pix_t rdata [RING_ROWS];
	col_t col_in;
	col_t cells [SPAN];
	pix_t masked [SPAN];
	logic [TREE_N-1:0][7:0] colv, winv;

	// configuration port
	assign pready  = 1'b1;
	assign ridx    = reg_idx_t'(paddr[2]);
	assign restart = psel && penable && pwrite;

	always_comb begin
		unique case (ridx)
			REG_WIDTH:  prdata = 32'(fw_q);
			REG_HEIGHT: prdata = 32'(fh_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= WIDTH_RESET;
			fh_q <= HEIGHT_RESET;
		end else if (restart) begin
			unique case (ridx)
				REG_WIDTH:  fw_q <= pwdata[CFG_W_W-1:0];
				REG_HEIGHT: fh_q <= pwdata[CFG_H_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		if (fw_q == '0) begin
			w_eff = WEFF_W'(1);
		end else if (32'(fw_q) > MAX_WIDTH) begin
			w_eff = WEFF_W'(MAX_WIDTH);
		end else begin
			w_eff = WEFF_W'(fw_q);
		end
		h_eff = (fh_q == '0) ? ROW_W'(1) : fh_q;
	end

	assign en = !out_vld_q || m_axis_tready;

	wmef_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.w_eff    (w_eff),
		.h_eff    (h_eff),
		.en       (en),
		.s_valid  (s_axis_tvalid),
		.s_action (s_axis_tuser),
		.s_ready  (s_axis_tready),
		.wr       (wr),
		.rd       (rd)
	);

	// line store: one bank per ring row, all read at the same column
	for (genvar b = 0; b < RING_ROWS; b++) begin : g_bank
		wmef_line_bank u_bank (
			.clk   (clk),
			.we    (wr.en && wr.bank == BANK_W'(b)),
			.waddr (wr.col),
			.wdata (s_axis_tdata),
			.re    (en && rd.go),
			.raddr (rd.col),
			.rdata (rdata[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
		end else if (restart) begin
			go_s1 <= 1'b0;
		end else if (en) begin
			go_s1 <= rd.go;
		end
	end

	always_ff @(posedge clk) begin
		if (en && rd.go) begin
			rd_s1 <= rd;
		end
	end

	// vertical minimum of the column over the window rows
	always_comb begin
		colv = '1;
		for (int b = 0; b < RING_ROWS; b++) begin
			if (rd_s1.mask[b]) begin
				colv[b] = rdata[b];
			end
		end
		col_in.vld = rd_s1.vld;
		col_in.tag = rd_s1.tag;
		col_in.val = min_tree(colv);
	end

	for (genvar k = 0; k < SPAN; k++) begin : g_cell
		wmef_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.clr    (restart),
			.shift  (en && go_s1),
			.din    ((k == 0) ? col_in : cells[(k == 0) ? 0 : k - 1]),
			.ctag   (cells[HALF].tag),
			.dout   (cells[k]),
			.masked (masked[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
		end else if (restart) begin
			emit_s2 <= 1'b0;
		end else if (en) begin
			emit_s2 <= go_s1 && rd_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en && go_s1) begin
			last_s2 <= rd_s1.last;
		end
	end

	always_comb begin
		winv = '1;
		for (int k = 0; k < SPAN; k++) begin
			winv[k] = masked[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (restart) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && emit_s2) begin
			out_min_q  <= min_tree(winv);
			out_last_q <= last_s2;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_min_q;
	assign m_axis_tlast  = out_last_q;

endmodule
